// ----- rtl/rbd_pkg.sv -----
// Shared types and constants for the ring buffer deque.
`default_nettype none

package rbd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;

    typedef enum logic [1:0] {
        OP_PUSH_TAIL = 2'd0,
        OP_POP_TAIL  = 2'd1,
        OP_PUSH_HEAD = 2'd2,
        OP_POP_HEAD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/rbd_req_if.sv -----
// Request channel interface: operation and push word.
`default_nettype none

interface rbd_req_if
    import rbd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/rbd_rsp_if.sv -----
// Response channel interface: popped word, status and occupancy.
`default_nettype none

interface rbd_rsp_if
    import rbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) ();
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] pop_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         occupancy;

    modport source (output valid, output pop_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/ring_buffer_deque.sv -----
// Top level of the ring buffer deque: controller plus datapath.
// The deque holds up to DEPTH signed 32-bit words in a circular memory and takes one
// request at a time: push or pop at the tail end or the head end. Each request gives
// exactly one response carrying the popped word (all ones for pushes, rejected pushes
// and pops on an empty deque), a status (ok, empty, full) and the occupancy after the
// request. On acceptance the pointers are updated and the slot memory, whose read
// data is registered, is read or written; the result then moves into the output
// register once that register is free. The next request is accepted only after that
// result is loaded, so no new request is taken while one is in flight, and the deque
// stalls while the response side has not taken the pending response. No memory
// clearing is needed after reset; slots are only read after they have been written.
`default_nettype none

module ring_buffer_deque
    import rbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rbd_req_if.sink    i_req,
    rbd_rsp_if.source  o_rsp
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;
    logic       req_ready;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rbd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_operation  (i_req.operation),
        .i_push_value (i_req.push_value),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_pop_value  (o_rsp.pop_value),
        .o_status     (o_rsp.status),
        .o_occupancy  (o_rsp.occupancy)
    );

    assign i_req.ready = req_ready;

endmodule

`default_nettype wire

// ----- rtl/rbd_ctrl.sv -----
// Controller state machine that sequences one request at a time.
`default_nettype none

module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    input  wire t_dp_status i_sts,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                // The memory access is done; move the result out once the output register frees.
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_start_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_EXEC))
        else $error("start did not move controller to execute");

    a_no_start_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_cmd.start)
        else $error("new request started while one is in flight");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after loading result");

endmodule

`default_nettype wire

// ----- rtl/rbd_dpath.sv -----
// Datapath: slot memory, head and tail pointers, element count and result register.
`default_nettype none

module rbd_dpath
    import rbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctrl_cmd                i_cmd,
    output t_dp_status                    o_sts,
    input  wire logic [1:0]               i_operation,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    input  wire logic                     i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic signed [WORD_W-1:0]      o_pop_value,
    output logic [1:0]                    o_status,
    output logic [CNT_W-1:0]              o_occupancy
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_res_status, n_res_status;
    logic             r_res_pop_ok, n_res_pop_ok;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_pop;
    logic [1:0]               r_out_status;
    logic [CNT_W-1:0]         r_out_occ;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;

    t_op              op;
    logic             is_push;
    logic             is_empty;
    logic             is_full;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] tail_dec;
    logic [PTR_W-1:0] head_inc;

    always_comb begin
        op       = t_op'(i_operation);
        is_push  = (op == OP_PUSH_TAIL) || (op == OP_PUSH_HEAD);
        is_empty = (r_count == '0);
        is_full  = (r_count == CNT_FULL);
        tail_inc = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
        head_inc = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
        tail_dec = (r_tail == '0) ? PTR_LAST : r_tail - PTR_W'(1);
        head_dec = (r_head == '0) ? PTR_LAST : r_head - PTR_W'(1);

        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_pop_ok = r_res_pop_ok;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = (op == OP_POP_TAIL) ? r_tail : r_head;

        if (i_cmd.start) begin
            n_res_status = ST_OK;
            n_res_pop_ok = 1'b0;
            if (is_push) begin
                if (is_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (is_empty) begin
                        // An empty deque restarts both pointers at slot zero.
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                    end else if (op == OP_PUSH_TAIL) begin
                        n_tail  = tail_inc;
                        wr_addr = tail_inc;
                    end else begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                    end
                end
            end else begin
                if (is_empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    rd_en        = 1'b1;
                    n_res_pop_ok = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    if (op == OP_POP_TAIL) begin
                        n_tail = tail_dec;
                    end else begin
                        n_head = head_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_push_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_res_status <= ST_OK;
            r_res_pop_ok <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_res_status <= n_res_status;
            r_res_pop_ok <= n_res_pop_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pop    <= r_res_pop_ok ? $signed(r_rd_data) : '1;
            r_out_status <= r_res_status;
            r_out_occ    <= r_count;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_rsp_ready;
    assign o_rsp_valid    = r_out_valid;
    assign o_pop_value    = r_out_pop;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("element count exceeds capacity");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && is_push && is_full)
            |=> ($stable(r_count) && $stable(r_head) && $stable(r_tail)
                 && (r_res_status == ST_FULL)))
        else $error("rejected push changed deque state");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && !is_push && !is_empty)
            |=> (r_count == $past(r_count) - CNT_W'(1)) && r_res_pop_ok)
        else $error("pop did not remove exactly one word");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && !i_rsp_ready))
        else $error("result register overwritten while still pending");

endmodule

`default_nettype wire
